/* rtl/core/mbist_pkg.sv */
// ----------------------------------------------------------------------------
// mbist_pkg
// Shared codes and types for the memory bus and cell self-test sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package mbist_pkg;

  // Sequencer phase codes
  localparam logic [4:0] PH_IDLE        = 5'd0;
  localparam logic [4:0] PH_DB_W        = 5'd1;
  localparam logic [4:0] PH_DB_R        = 5'd2;
  localparam logic [4:0] PH_AB_FILL     = 5'd3;
  localparam logic [4:0] PH_AB_ANTI0    = 5'd4;
  localparam logic [4:0] PH_AB_CHK      = 5'd5;
  localparam logic [4:0] PH_AB_RESTORE0 = 5'd6;
  localparam logic [4:0] PH_AB_PW       = 5'd7;
  localparam logic [4:0] PH_AB_P0       = 5'd8;
  localparam logic [4:0] PH_AB_PCHK     = 5'd9;
  localparam logic [4:0] PH_AB_PRESTORE = 5'd10;
  localparam logic [4:0] PH_DV_FILL     = 5'd11;
  localparam logic [4:0] PH_DV_CHK      = 5'd12;
  localparam logic [4:0] PH_DV_INV      = 5'd13;
  localparam logic [4:0] PH_DV_ICHK     = 5'd14;
  localparam logic [4:0] PH_DV_CLR      = 5'd15;
  localparam logic [4:0] PH_DONE        = 5'd16;

  // Result operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_PASS  = 2'd2;
  localparam logic [1:0] OP_FAIL  = 2'd3;

  // Failing test codes
  localparam logic [1:0] FT_NONE = 2'd0;
  localparam logic [1:0] FT_DATA = 2'd1;
  localparam logic [1:0] FT_ADDR = 2'd2;
  localparam logic [1:0] FT_DEV  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_BASE   = 2'd0;
  localparam logic [1:0] CFG_REGION = 2'd1;
  localparam logic [1:0] CFG_MASK   = 2'd2;

  // Test mask bits
  localparam int MASK_DB = 0;
  localparam int MASK_AB = 1;
  localparam int MASK_DV = 2;

  localparam int CFG_W  = 17;
  localparam int OFF_W  = 17;
  localparam int BASE_W = 16;

  localparam logic [15:0] PAT_A = 16'hAAAA;
  localparam logic [15:0] PAT_N = 16'h5555;

  // Step passes: at most six silent phase hops, then the one that issues
  localparam int MAX_PASSES = 7;

  typedef struct packed {
    logic [BASE_W-1:0] base_address;
    logic [OFF_W-1:0]  region_words;
    logic [2:0]        test_mask;
  } cfg_t;

  typedef struct packed {
    logic [4:0]       phase;
    logic [OFF_W-1:0] offset;
    logic [OFF_W-1:0] probe_offset;
    logic             read_pending;
    logic [1:0]       pend_test;
  } ctl_t;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] failed_test;
  } res_t;

endpackage

`default_nettype wire

/* rtl/core/mbist_step.sv */
// ----------------------------------------------------------------------------
// mbist_step
// Next-step logic: checks a returned read and picks the next operation.
// ----------------------------------------------------------------------------
`default_nettype none

module mbist_step #(
  parameter int DATA_WIDTH = 16,
  parameter int ADDR_WIDTH = 16
) (
  input  mbist_pkg::cfg_t        cfg,
  input  mbist_pkg::ctl_t        ctl,
  input  logic [DATA_WIDTH-1:0]  pattern,
  input  logic [DATA_WIDTH-1:0]  expected,
  input  logic [DATA_WIDTH-1:0]  pend_value,
  input  logic                   kind,
  input  logic [DATA_WIDTH-1:0]  read_data,
  output mbist_pkg::ctl_t        ctl_next,
  output logic [DATA_WIDTH-1:0]  pattern_next,
  output logic [DATA_WIDTH-1:0]  expected_next,
  output logic [DATA_WIDTH-1:0]  pend_value_next,
  output logic                   emit,
  output mbist_pkg::res_t        res,
  output logic [ADDR_WIDTH-1:0]  address,
  output logic [DATA_WIDTH-1:0]  write_data,
  output logic [DATA_WIDTH-1:0]  fail_value
);

  localparam int OW = mbist_pkg::OFF_W;
  localparam int SW = (ADDR_WIDTH > OW + 1) ? ADDR_WIDTH : OW + 1;

  // data source select
  localparam logic [2:0] DS_PAT  = 3'd0;
  localparam logic [2:0] DS_A    = 3'd1;
  localparam logic [2:0] DS_N    = 3'd2;
  localparam logic [2:0] DS_INC  = 3'd3;
  localparam logic [2:0] DS_INV  = 3'd4;
  localparam logic [2:0] DS_ZERO = 3'd5;

  // fail value source select
  localparam logic [1:0] PV_PAT = 2'd0;
  localparam logic [1:0] PV_OFF = 2'd1;
  localparam logic [1:0] PV_PRB = 2'd2;

  function automatic logic [ADDR_WIDTH-1:0] addr_of(input logic [OW-1:0] off,
                                                    input logic [15:0] base);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    return sum[ADDR_WIDTH-1:0];
  endfunction

  logic [4:0]            ph;
  logic [OW-1:0]         off;
  logic [OW-1:0]         prb;
  logic [OW-1:0]         ao;
  logic [OW-1:0]         amask;
  logic [OW-1:0]         n;
  logic [OW-1:0]         ao_inc;
  logic [DATA_WIDTH-1:0] pat;
  logic [DATA_WIDTH-1:0] dp;
  logic [DATA_WIDTH-1:0] data;
  logic [ADDR_WIDTH-1:0] op_addr;
  logic                  rp;
  logic                  go;
  logic [1:0]            op;
  logic [1:0]            pt;
  logic [1:0]            ft;
  logic [2:0]            dsel;
  logic [1:0]            pvsel;

  assign n     = cfg.region_words;
  assign amask = (cfg.region_words != '0) ? (cfg.region_words - OW'(1)) : '0;

  always_comb begin
    ph    = ctl.phase;
    off   = ctl.offset;
    prb   = ctl.probe_offset;
    rp    = ctl.read_pending;
    pt    = ctl.pend_test;
    pat   = pattern;
    go    = 1'b0;
    emit  = 1'b0;
    op    = mbist_pkg::OP_WRITE;
    ft    = mbist_pkg::FT_NONE;
    ao    = '0;
    dp    = pattern;
    dsel  = DS_ZERO;
    pvsel = PV_PAT;
    fail_value = '0;

    if (!kind) begin
      ph  = mbist_pkg::PH_DB_W;
      pat = DATA_WIDTH'(1);
      off = '0;
      prb = '0;
      rp  = 1'b0;
      go  = 1'b1;
    end else if (ph == mbist_pkg::PH_IDLE) begin
      go = 1'b0;
    end else if (rp && (read_data != expected)) begin
      ph   = mbist_pkg::PH_IDLE;
      rp   = 1'b0;
      emit = 1'b1;
      op   = mbist_pkg::OP_FAIL;
      ft   = ctl.pend_test;
      fail_value = pend_value;
    end else begin
      go = 1'b1;
    end

    // Walk through silent phase hops until an operation or verdict comes out
    for (int i = 0; i < mbist_pkg::MAX_PASSES; i++) begin
      if (go) begin
        case (ph)
          mbist_pkg::PH_DB_W: begin
            if (!cfg.test_mask[mbist_pkg::MASK_DB] || pat == '0) begin
              ph  = mbist_pkg::PH_AB_FILL;
              off = OW'(1);
            end else begin
              ph = mbist_pkg::PH_DB_R;
              go = 1'b0; emit = 1'b1; op = mbist_pkg::OP_WRITE; rp = 1'b0;
              ao = '0; dp = pat; dsel = DS_PAT;
            end
          end
          mbist_pkg::PH_DB_R: begin
            dp  = pat;
            pat = pat << 1;
            ph  = mbist_pkg::PH_DB_W;
            go = 1'b0; emit = 1'b1; op = mbist_pkg::OP_READ; rp = 1'b1;
            ao = '0; dsel = DS_PAT; pt = mbist_pkg::FT_DATA; pvsel = PV_PAT;
          end
          mbist_pkg::PH_AB_FILL: begin
            if (!cfg.test_mask[mbist_pkg::MASK_AB]) begin
              ph  = mbist_pkg::PH_DV_FILL;
              off = '0;
            end else if ((off & amask) == '0) begin
              ph = mbist_pkg::PH_AB_ANTI0;
            end else begin
              ao  = off;
              off = off << 1;
              go = 1'b0; emit = 1'b1; op = mbist_pkg::OP_WRITE; rp = 1'b0;
              dsel = DS_A;
            end
          end
          mbist_pkg::PH_AB_ANTI0: begin
            off = OW'(1);
            ph  = mbist_pkg::PH_AB_CHK;
            go = 1'b0; emit = 1'b1; op = mbist_pkg::OP_WRITE; rp = 1'b0;
            ao = '0; dsel = DS_N;
          end
          mbist_pkg::PH_AB_CHK: begin
            if ((off & amask) == '0) begin
              ph = mbist_pkg::PH_AB_RESTORE0;
            end else begin
              ao  = off;
              off = off << 1;
              go = 1'b0; emit = 1'b1; op = mbist_pkg::OP_READ; rp = 1'b1;
              dsel = DS_A; pt = mbist_pkg::FT_ADDR; pvsel = PV_OFF;
            end
          end
          mbist_pkg::PH_AB_RESTORE0: begin
            prb = OW'(1);
            ph  = mbist_pkg::PH_AB_PW;
            go = 1'b0; emit = 1'b1; op = mbist_pkg::OP_WRITE; rp = 1'b0;
            ao = '0; dsel = DS_A;
          end
          mbist_pkg::PH_AB_PW: begin
            if ((prb & amask) == '0) begin
              ph  = mbist_pkg::PH_DV_FILL;
              off = '0;
            end else begin
              ph = mbist_pkg::PH_AB_P0;
              go = 1'b0; emit = 1'b1; op = mbist_pkg::OP_WRITE; rp = 1'b0;
              ao = prb; dsel = DS_N;
            end
          end
          mbist_pkg::PH_AB_P0: begin
            off = OW'(1);
            ph  = mbist_pkg::PH_AB_PCHK;
            go = 1'b0; emit = 1'b1; op = mbist_pkg::OP_READ; rp = 1'b1;
            ao = '0; dsel = DS_A; pt = mbist_pkg::FT_ADDR; pvsel = PV_PRB;
          end
          mbist_pkg::PH_AB_PCHK: begin
            // the probed bit itself is skipped
            if (off == prb) off = off << 1;
            if ((off & amask) == '0) begin
              ph = mbist_pkg::PH_AB_PRESTORE;
            end else begin
              ao  = off;
              off = off << 1;
              go = 1'b0; emit = 1'b1; op = mbist_pkg::OP_READ; rp = 1'b1;
              dsel = DS_A; pt = mbist_pkg::FT_ADDR; pvsel = PV_PRB;
            end
          end
          mbist_pkg::PH_AB_PRESTORE: begin
            ao  = prb;
            prb = prb << 1;
            ph  = mbist_pkg::PH_AB_PW;
            go = 1'b0; emit = 1'b1; op = mbist_pkg::OP_WRITE; rp = 1'b0;
            dsel = DS_A;
          end
          mbist_pkg::PH_DV_FILL: begin
            if (!cfg.test_mask[mbist_pkg::MASK_DV]) begin
              ph = mbist_pkg::PH_DONE;
            end else if (off >= n) begin
              off = '0;
              ph  = mbist_pkg::PH_DV_CHK;
            end else begin
              ao  = off;
              off = off + OW'(1);
              go = 1'b0; emit = 1'b1; op = mbist_pkg::OP_WRITE; rp = 1'b0;
              dsel = DS_INC;
            end
          end
          mbist_pkg::PH_DV_CHK: begin
            if (off >= n) begin
              off = '0;
              ph  = mbist_pkg::PH_DV_ICHK;
            end else begin
              ao = off;
              ph = mbist_pkg::PH_DV_INV;
              go = 1'b0; emit = 1'b1; op = mbist_pkg::OP_READ; rp = 1'b1;
              dsel = DS_INC; pt = mbist_pkg::FT_DEV; pvsel = PV_OFF;
            end
          end
          mbist_pkg::PH_DV_INV: begin
            ao  = off;
            off = off + OW'(1);
            ph  = mbist_pkg::PH_DV_CHK;
            go = 1'b0; emit = 1'b1; op = mbist_pkg::OP_WRITE; rp = 1'b0;
            dsel = DS_INV;
          end
          mbist_pkg::PH_DV_ICHK: begin
            if (off >= n) begin
              off = '0;
              ph  = mbist_pkg::PH_DV_CLR;
            end else begin
              ao  = off;
              off = off + OW'(1);
              go = 1'b0; emit = 1'b1; op = mbist_pkg::OP_READ; rp = 1'b1;
              dsel = DS_INV; pt = mbist_pkg::FT_DEV; pvsel = PV_OFF;
            end
          end
          mbist_pkg::PH_DV_CLR: begin
            if (off >= n) begin
              ph = mbist_pkg::PH_DONE;
            end else begin
              ao  = off;
              off = off + OW'(1);
              go = 1'b0; emit = 1'b1; op = mbist_pkg::OP_WRITE; rp = 1'b0;
              dsel = DS_ZERO;
            end
          end
          mbist_pkg::PH_DONE: begin
            ph = mbist_pkg::PH_IDLE;
            rp = 1'b0;
            go = 1'b0; emit = 1'b1; op = mbist_pkg::OP_PASS;
          end
          default: begin
            ph = mbist_pkg::PH_IDLE;
            rp = 1'b0;
            go = 1'b0;
          end
        endcase
      end
    end
  end

  assign ao_inc  = ao + OW'(1);
  assign op_addr = addr_of(ao, cfg.base_address);

  always_comb begin
    case (dsel)
      DS_PAT:  data = dp;
      DS_A:    data = DATA_WIDTH'(mbist_pkg::PAT_A);
      DS_N:    data = DATA_WIDTH'(mbist_pkg::PAT_N);
      DS_INC:  data = DATA_WIDTH'(ao_inc);
      DS_INV:  data = ~DATA_WIDTH'(ao_inc);
      default: data = '0;
    endcase
  end

  always_comb begin
    ctl_next.phase        = ph;
    ctl_next.offset       = off;
    ctl_next.probe_offset = prb;
    ctl_next.read_pending = rp;
    ctl_next.pend_test    = pt;
    pattern_next          = pat;
    expected_next         = expected;
    pend_value_next       = pend_value;
    if (emit && op == mbist_pkg::OP_READ) begin
      expected_next = data;
      case (pvsel)
        PV_PAT:  pend_value_next = dp;
        PV_OFF:  pend_value_next = DATA_WIDTH'(op_addr);
        PV_PRB:  pend_value_next = DATA_WIDTH'(addr_of(prb, cfg.base_address));
        default: pend_value_next = '0;
      endcase
    end
  end

  assign res.op          = op;
  assign res.failed_test = ft;
  assign address    = (op == mbist_pkg::OP_WRITE || op == mbist_pkg::OP_READ) ? op_addr : '0;
  assign write_data = (op == mbist_pkg::OP_WRITE) ? data : '0;

endmodule

`default_nettype wire

/* rtl/core/memory_bus_and_cell_self_test.sv */
// ----------------------------------------------------------------------------
// memory_bus_and_cell_self_test
// Memory self-test sequencer: walking-ones data bus, address bus and device
// tests run in order, each enabled by test_mask, stopping at the first
// failure. A start item (kind 0) begins a run; each later item (kind 1)
// acknowledges the last issued operation and carries its read data. Each
// accepted item yields at most one result: the next write or read, or a
// pass/fail verdict with the failing test and pattern or word address. An
// acknowledge while idle yields nothing. The block takes one item per clock
// while in_stall is low: the item is registered, then the step logic (read
// check plus up to six silent phase hops, each a 17-bit compare or increment)
// feeds the result register. The result register lets the next
// item be processed in the cycle its predecessor is taken downstream.
// Configuration is read live at each step and should be written while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module memory_bus_and_cell_self_test #(
  parameter int DATA_WIDTH = 16,
  parameter int ADDR_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [mbist_pkg::CFG_W-1:0]   cfg_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          kind,
  input  logic [DATA_WIDTH-1:0]         read_data,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    op,
  output logic [ADDR_WIDTH-1:0]         address,
  output logic [DATA_WIDTH-1:0]         write_data,
  output logic [1:0]                    failed_test,
  output logic [DATA_WIDTH-1:0]         fail_value
);

  // configuration
  mbist_pkg::cfg_t cfg;

  // input register
  logic                  s1_valid;
  logic                  s1_kind;
  logic [DATA_WIDTH-1:0] s1_rdata;

  // sequencer state
  mbist_pkg::ctl_t       ctl;
  mbist_pkg::ctl_t       ctl_next;
  logic [DATA_WIDTH-1:0] pattern;
  logic [DATA_WIDTH-1:0] pattern_next;
  logic [DATA_WIDTH-1:0] expected;
  logic [DATA_WIDTH-1:0] expected_next;
  logic [DATA_WIDTH-1:0] pend_value;
  logic [DATA_WIDTH-1:0] pend_value_next;

  // step results
  logic                  emit;
  mbist_pkg::res_t       res;
  logic [ADDR_WIDTH-1:0] res_address;
  logic [DATA_WIDTH-1:0] res_write_data;
  logic [DATA_WIDTH-1:0] res_fail_value;

  logic adv;
  logic in_take;

  // The registered item is consumed when the result register is free or
  // being emptied this cycle.
  assign adv      = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_address <= '0;
      cfg.region_words <= 17'h10000;
      cfg.test_mask    <= 3'b111;
    end else if (cfg_we) begin
      case (cfg_index)
        mbist_pkg::CFG_BASE:   cfg.base_address <= cfg_data[mbist_pkg::BASE_W-1:0];
        mbist_pkg::CFG_REGION: cfg.region_words <= cfg_data[mbist_pkg::OFF_W-1:0];
        mbist_pkg::CFG_MASK:   cfg.test_mask    <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_kind  <= kind;
      s1_rdata <= read_data;
    end
  end

  mbist_step #(
    .DATA_WIDTH (DATA_WIDTH),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_step (
    .cfg             (cfg),
    .ctl             (ctl),
    .pattern         (pattern),
    .expected        (expected),
    .pend_value      (pend_value),
    .kind            (s1_kind),
    .read_data       (s1_rdata),
    .ctl_next        (ctl_next),
    .pattern_next    (pattern_next),
    .expected_next   (expected_next),
    .pend_value_next (pend_value_next),
    .emit            (emit),
    .res             (res),
    .address         (res_address),
    .write_data      (res_write_data),
    .fail_value      (res_fail_value)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.phase        <= mbist_pkg::PH_IDLE;
      ctl.offset       <= '0;
      ctl.probe_offset <= '0;
      ctl.read_pending <= 1'b0;
      ctl.pend_test    <= mbist_pkg::FT_NONE;
    end else if (adv) begin
      ctl <= ctl_next;
    end
  end

  // data state; only looked at behind read_pending or after a start
  always_ff @(posedge clk) begin
    if (adv) begin
      pattern    <= pattern_next;
      expected   <= expected_next;
      pend_value <= pend_value_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      op          <= res.op;
      address     <= res_address;
      write_data  <= res_write_data;
      failed_test <= res.failed_test;
      fail_value  <= res_fail_value;
    end
  end

`ifndef NO_ASSERTIONS
  // A read can only be outstanding inside a run.
  a_pending_in_run: assert property (@(posedge clk) disable iff (rst)
    ctl.read_pending |-> ctl.phase != mbist_pkg::PH_IDLE)
    else $error("read pending while sequencer idle");

  // Input is held off only by a full, stalled result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // A verdict always leaves the sequencer idle.
  a_verdict_idle: assert property (@(posedge clk) disable iff (rst)
    (adv && emit && (res.op == mbist_pkg::OP_PASS || res.op == mbist_pkg::OP_FAIL))
    |=> ctl.phase == mbist_pkg::PH_IDLE)
    else $error("sequencer not idle after verdict");

  // The address probe walks a single bit.
  a_probe_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(ctl.probe_offset))
    else $error("probe offset has more than one bit set");
`endif

endmodule

`default_nettype wire

/* tb/tb_memory_bus_and_cell_self_test.sv */
// ----------------------------------------------------------------------------
// tb_memory_bus_and_cell_self_test
// Self-checking bench for the memory self-test sequencer. The bench plays the
// memory: it answers every write or read the block issues, mostly with the
// data a sound memory returns and sometimes with a flipped bit. A predictor
// of the sequencer, kept in step with each accepted item, supplies both the
// read data for the next acknowledge and the result expected from the block.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_memory_bus_and_cell_self_test;
  timeunit 1ns;
  timeprecision 1ps;

  // item kinds on the input channel
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_ACK   = 1'b1;

  localparam int RANDOM_ITEMS = 650;
  localparam int HOLD_CYCLES  = 150;     // long receiver hold-off
  localparam int TIMEOUT_NS   = 10_000_000;

  // one memory operation or verdict, as it leaves the block
  typedef struct {
    logic [1:0]  op;
    logic [15:0] addr;
    logic [15:0] wdata;
    logic [1:0]  ft;
    logic [15:0] fv;
  } mem_op_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [mbist_pkg::CFG_W-1:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        kind;
  logic [15:0] read_data;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  op;
  logic [15:0] address;
  logic [15:0] write_data;
  logic [1:0]  failed_test;
  logic [15:0] fail_value;

  memory_bus_and_cell_self_test uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .read_data   (read_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .op          (op),
    .address     (address),
    .write_data  (write_data),
    .failed_test (failed_test),
    .fail_value  (fail_value)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: register copies and the sequencer's own state
  // --------------------------------------------------------------------------
  logic [15:0] cfg_base;
  logic [16:0] cfg_region;
  logic [2:0]  cfg_mask;

  logic [4:0]  seq_phase;
  logic [16:0] walk_off;
  logic [16:0] probe_off;
  logic [15:0] walk_pat;
  logic [15:0] want_word;     // data the pending read must return
  logic        read_owed;     // last issued operation was a read
  logic [1:0]  owed_test;     // verdict fields if that read comes back wrong
  logic [15:0] owed_value;

  mem_op_t ops_due[$];        // results the block still owes, oldest first

  // knobs and counters
  int tx_gap_pct   = 33;
  int rx_stall_pct = 33;
  int hold_orders  = 0;
  int items_sent   = 0;
  int results_checked = 0;
  int mismatches   = 0;
  int pass_verdicts = 0;
  int fail_verdicts = 0;
  int restarts     = 0;
  int input_stalls = 0;
  int reg_writes   = 0;

  // word address of an offset in the region; wraps at 16 bits
  function automatic logic [15:0] word_addr(input logic [16:0] o);
    return cfg_base + o[15:0];
  endfunction

  function automatic logic [16:0] dbl(input logic [16:0] o);
    return {o[15:0], 1'b0};
  endfunction

  function automatic mem_op_t op_write(input logic [16:0] o, input logic [15:0] d);
    mem_op_t r;
    read_owed = 1'b0;
    r.op = mbist_pkg::OP_WRITE; r.addr = word_addr(o); r.wdata = d;
    r.ft = mbist_pkg::FT_NONE; r.fv = '0;
    return r;
  endfunction

  function automatic mem_op_t op_read(input logic [16:0] o, input logic [15:0] e,
                                      input logic [1:0] ft, input logic [15:0] fv);
    mem_op_t r;
    read_owed = 1'b1;
    want_word = e;
    owed_test = ft;
    owed_value = fv;
    r.op = mbist_pkg::OP_READ; r.addr = word_addr(o); r.wdata = '0;
    r.ft = mbist_pkg::FT_NONE; r.fv = '0;
    return r;
  endfunction

  function automatic mem_op_t op_verdict(input logic [1:0] code, input logic [1:0] ft,
                                         input logic [15:0] fv);
    mem_op_t r;
    read_owed = 1'b0;
    r.op = code; r.addr = '0; r.wdata = '0; r.ft = ft; r.fv = fv;
    return r;
  endfunction

  // Advance through silent phase hops until an operation or verdict comes out.
  function automatic mem_op_t next_mem_op();
    logic [16:0] amask;
    logic [16:0] o;
    logic [15:0] p;
    mem_op_t     r;
    bit          found;
    amask = (cfg_region != 17'd0) ? cfg_region - 17'd1 : 17'd0;
    found = 1'b0;
    r = op_verdict(mbist_pkg::OP_PASS, mbist_pkg::FT_NONE, '0);
    while (!found) begin
      case (seq_phase)
        mbist_pkg::PH_DB_W: begin
          if (!cfg_mask[mbist_pkg::MASK_DB] || walk_pat == 16'd0) begin
            seq_phase = mbist_pkg::PH_AB_FILL; walk_off = 17'd1;
          end else begin
            seq_phase = mbist_pkg::PH_DB_R; r = op_write(17'd0, walk_pat); found = 1'b1;
          end
        end
        mbist_pkg::PH_DB_R: begin
          p = walk_pat;
          walk_pat = walk_pat << 1;
          seq_phase = mbist_pkg::PH_DB_W;
          r = op_read(17'd0, p, mbist_pkg::FT_DATA, p); found = 1'b1;
        end
        mbist_pkg::PH_AB_FILL: begin
          if (!cfg_mask[mbist_pkg::MASK_AB]) begin
            seq_phase = mbist_pkg::PH_DV_FILL; walk_off = 17'd0;
          end else if ((walk_off & amask) == 17'd0) begin
            seq_phase = mbist_pkg::PH_AB_ANTI0;
          end else begin
            o = walk_off; walk_off = dbl(walk_off);
            r = op_write(o, mbist_pkg::PAT_A); found = 1'b1;
          end
        end
        mbist_pkg::PH_AB_ANTI0: begin
          walk_off = 17'd1; seq_phase = mbist_pkg::PH_AB_CHK;
          r = op_write(17'd0, mbist_pkg::PAT_N); found = 1'b1;
        end
        mbist_pkg::PH_AB_CHK: begin
          if ((walk_off & amask) == 17'd0) begin
            seq_phase = mbist_pkg::PH_AB_RESTORE0;
          end else begin
            o = walk_off; walk_off = dbl(walk_off);
            r = op_read(o, mbist_pkg::PAT_A, mbist_pkg::FT_ADDR, word_addr(o));
            found = 1'b1;
          end
        end
        mbist_pkg::PH_AB_RESTORE0: begin
          probe_off = 17'd1; seq_phase = mbist_pkg::PH_AB_PW;
          r = op_write(17'd0, mbist_pkg::PAT_A); found = 1'b1;
        end
        mbist_pkg::PH_AB_PW: begin
          if ((probe_off & amask) == 17'd0) begin
            seq_phase = mbist_pkg::PH_DV_FILL; walk_off = 17'd0;
          end else begin
            seq_phase = mbist_pkg::PH_AB_P0;
            r = op_write(probe_off, mbist_pkg::PAT_N); found = 1'b1;
          end
        end
        mbist_pkg::PH_AB_P0: begin
          walk_off = 17'd1; seq_phase = mbist_pkg::PH_AB_PCHK;
          r = op_read(17'd0, mbist_pkg::PAT_A, mbist_pkg::FT_ADDR, word_addr(probe_off));
          found = 1'b1;
        end
        mbist_pkg::PH_AB_PCHK: begin
          // the probed offset holds the anti-pattern, so it is skipped
          if (walk_off == probe_off) walk_off = dbl(walk_off);
          if ((walk_off & amask) == 17'd0) begin
            seq_phase = mbist_pkg::PH_AB_PRESTORE;
          end else begin
            o = walk_off; walk_off = dbl(walk_off);
            r = op_read(o, mbist_pkg::PAT_A, mbist_pkg::FT_ADDR, word_addr(probe_off));
            found = 1'b1;
          end
        end
        mbist_pkg::PH_AB_PRESTORE: begin
          o = probe_off; probe_off = dbl(probe_off); seq_phase = mbist_pkg::PH_AB_PW;
          r = op_write(o, mbist_pkg::PAT_A); found = 1'b1;
        end
        mbist_pkg::PH_DV_FILL: begin
          if (!cfg_mask[mbist_pkg::MASK_DV]) begin
            seq_phase = mbist_pkg::PH_DONE;
          end else if (walk_off >= cfg_region) begin
            walk_off = 17'd0; seq_phase = mbist_pkg::PH_DV_CHK;
          end else begin
            o = walk_off; walk_off = walk_off + 17'd1;
            r = op_write(o, o[15:0] + 16'd1); found = 1'b1;
          end
        end
        mbist_pkg::PH_DV_CHK: begin
          if (walk_off >= cfg_region) begin
            walk_off = 17'd0; seq_phase = mbist_pkg::PH_DV_ICHK;
          end else begin
            seq_phase = mbist_pkg::PH_DV_INV;
            r = op_read(walk_off, walk_off[15:0] + 16'd1, mbist_pkg::FT_DEV,
                        word_addr(walk_off));
            found = 1'b1;
          end
        end
        mbist_pkg::PH_DV_INV: begin
          o = walk_off; walk_off = walk_off + 17'd1; seq_phase = mbist_pkg::PH_DV_CHK;
          r = op_write(o, ~(o[15:0] + 16'd1)); found = 1'b1;
        end
        mbist_pkg::PH_DV_ICHK: begin
          if (walk_off >= cfg_region) begin
            walk_off = 17'd0; seq_phase = mbist_pkg::PH_DV_CLR;
          end else begin
            o = walk_off; walk_off = walk_off + 17'd1;
            r = op_read(o, ~(o[15:0] + 16'd1), mbist_pkg::FT_DEV, word_addr(o));
            found = 1'b1;
          end
        end
        mbist_pkg::PH_DV_CLR: begin
          if (walk_off >= cfg_region) begin
            seq_phase = mbist_pkg::PH_DONE;
          end else begin
            o = walk_off; walk_off = walk_off + 17'd1;
            r = op_write(o, 16'd0); found = 1'b1;
          end
        end
        default: begin   // PH_DONE
          seq_phase = mbist_pkg::PH_IDLE;
          r = op_verdict(mbist_pkg::OP_PASS, mbist_pkg::FT_NONE, '0); found = 1'b1;
        end
      endcase
    end
    return r;
  endfunction

  // One accepted item; returns 1 with the owed result when the block answers.
  function automatic bit sequencer_step(input logic k, input logic [15:0] rd,
                                        output mem_op_t r);
    r = '{default: '0};
    if (k == KIND_START) begin
      seq_phase = mbist_pkg::PH_DB_W;
      walk_pat = 16'd1;
      walk_off = '0;
      probe_off = '0;
      read_owed = 1'b0;
      r = next_mem_op();
      return 1'b1;
    end
    if (seq_phase == mbist_pkg::PH_IDLE) return 1'b0;   // acknowledge while idle: silent
    if (read_owed && rd != want_word) begin
      seq_phase = mbist_pkg::PH_IDLE;
      r = op_verdict(mbist_pkg::OP_FAIL, owed_test, owed_value);
      return 1'b1;
    end
    r = next_mem_op();
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so the caller either sends again or drains.
  task automatic send_item(input logic k, input logic [15:0] rd);
    mem_op_t r;
    while ($urandom_range(99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    read_data <= rd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (sequencer_step(k, rd, r)) ops_due.push_back(r);
    items_sent++;
    @(negedge clk);
  endtask

  // Wait until the block owes nothing, plus its pipeline depth for silent items.
  task automatic drain();
    in_valid <= 1'b0;
    while (ops_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_register(input logic [1:0] idx, input logic [16:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      mbist_pkg::CFG_BASE:   cfg_base = val[15:0];
      mbist_pkg::CFG_REGION: cfg_region = val;
      default:               cfg_mask = val[2:0];
    endcase
    reg_writes++;
  endtask

  // Start a run and answer it like a memory. bad_read picks which read gets
  // a flipped bit (-1: none); restart_pm is the per-mille chance of a fresh
  // start in the middle. n returns the number of items sent.
  task automatic drive_run(input int max_acks, input int bad_read, input int restart_pm,
                           output int n);
    int          reads;
    logic [15:0] rd;
    send_item(KIND_START, 16'($urandom));
    n = 1;
    reads = 0;
    while (seq_phase != mbist_pkg::PH_IDLE && n <= max_acks) begin
      if ($urandom_range(999) < restart_pm) begin
        send_item(KIND_START, 16'($urandom));
        restarts++;
      end else begin
        if (read_owed) begin
          rd = want_word;
          if (reads == bad_read) rd = rd ^ (16'd1 << $urandom_range(15));
          reads++;
        end else begin
          rd = 16'($urandom);       // write acknowledge: data is ignored
        end
        send_item(KIND_ACK, rd);
      end
      n++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: random stalls, plus long hold-offs on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int left;
    int served;
    left = 0;
    served = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_orders != served) begin
        served = hold_orders;
        left = HOLD_CYCLES;
      end
      if (left > 0) begin
        left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  task automatic compare_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] got_v);
    if (got_v !== exp_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
    end
  endtask

  // Every accepted result is matched against the oldest owed one.
  always @(posedge clk) begin : result_check
    mem_op_t e;
    if (!rst && in_valid && in_stall) input_stalls++;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (ops_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual op %0d address %h",
                 $time, op, address);
      end else begin
        e = ops_due.pop_front();
        results_checked++;
        if (e.op == mbist_pkg::OP_PASS) pass_verdicts++;
        if (e.op == mbist_pkg::OP_FAIL) fail_verdicts++;
        compare_field("op", 16'(e.op), 16'(op));
        compare_field("address", e.addr, address);
        compare_field("write_data", e.wdata, write_data);
        compare_field("failed_test", 16'(e.ft), 16'(failed_test));
        compare_field("fail_value", e.fv, fail_value);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // acknowledge with nothing running must stay silent
  task automatic test_idle_ack();
    send_item(KIND_ACK, 16'hFFFF);
  endtask

  // no test enabled: pass at once
  task automatic test_empty_mask();
    int n;
    drain();
    set_register(mbist_pkg::CFG_MASK, 17'd0);
    drive_run(10, -1, 0, n);
  endtask

  // zero-sized region: only the offset-0 writes of the address test remain
  task automatic test_zero_region();
    int n;
    drain();
    set_register(mbist_pkg::CFG_REGION, 17'd0);
    set_register(mbist_pkg::CFG_MASK, 17'(3'b110));
    drive_run(10, -1, 0, n);
  endtask

  // walking ones at the top address, first read comes back wrong
  task automatic test_data_bus_fault();
    int n;
    drain();
    set_register(mbist_pkg::CFG_BASE, 17'h0FFFF);
    set_register(mbist_pkg::CFG_REGION, 17'd4);
    set_register(mbist_pkg::CFG_MASK, 17'(3'b001));
    drive_run(10, 0, 0, n);
  endtask

  // full address-bus pass over a two-word region that wraps past 0xFFFF
  task automatic test_address_wrap();
    int n;
    drain();
    set_register(mbist_pkg::CFG_REGION, 17'd2);
    set_register(mbist_pkg::CFG_MASK, 17'(3'b010));
    drive_run(20, -1, 0, n);
  endtask

  // one-word device test, the inverted read-back fails
  task automatic test_device_fault();
    int n;
    drain();
    set_register(mbist_pkg::CFG_BASE, 17'd0);
    set_register(mbist_pkg::CFG_REGION, 17'd1);
    set_register(mbist_pkg::CFG_MASK, 17'(3'b100));
    drive_run(10, 1, 0, n);
  endtask

  // restart mid-run, then move the base while a run is paused
  task automatic test_restart_live_config();
    drain();
    set_register(mbist_pkg::CFG_REGION, 17'h10000);
    set_register(mbist_pkg::CFG_MASK, 17'(3'b111));
    send_item(KIND_START, 16'h0000);
    send_item(KIND_ACK, 16'h1234);
    send_item(KIND_START, 16'hFFFF);
    restarts++;
    send_item(KIND_ACK, 16'h0000);     // acknowledges a write, data ignored
    send_item(KIND_START, 16'h5A5A);
    restarts++;
    send_item(KIND_ACK, 16'hA5A5);
    drain();
    set_register(mbist_pkg::CFG_BASE, 17'h08001);
    send_item(KIND_ACK, want_word);
  endtask

  // receiver holds off for a long time while items keep coming
  task automatic test_backpressure();
    int n;
    drain();
    set_register(mbist_pkg::CFG_REGION, 17'd1);
    set_register(mbist_pkg::CFG_MASK, 17'(3'b001));
    hold_orders <= hold_orders + 1;
    tx_gap_pct = 0;
    drive_run(100, -1, 0, n);
    tx_gap_pct = 33;
  endtask

  // data and address tests over the whole address space, no idling either side
  task automatic test_full_address_space();
    int n;
    drain();
    set_register(mbist_pkg::CFG_BASE, 17'($urandom_range(16'hFFFF)));
    set_register(mbist_pkg::CFG_REGION, 17'h10000);
    set_register(mbist_pkg::CFG_MASK, 17'(3'b011));
    tx_gap_pct = 0;
    rx_stall_pct <= 0;
    drive_run(1000, -1, 0, n);
    drain();
    tx_gap_pct = 33;
    rx_stall_pct <= 33;
  endtask

  // random settings, mostly small regions; clean runs, faulty runs, restarts
  // and stray acknowledges
  task automatic test_random_runs();
    int          done_items;
    int          n;
    int          bad;
    int          pick;
    logic [15:0] base;
    logic [16:0] region;
    logic [2:0]  mask;
    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      drain();
      pick = $urandom_range(9);
      base = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
      mask = ($urandom_range(99) < 5) ? 3'd0 : 3'($urandom_range(7, 1));
      pick = $urandom_range(99);
      if (pick < 65)      region = 17'd1 << $urandom_range(5);
      else if (pick < 88) region = 17'($urandom_range(24, 1));
      else if (pick < 94) region = 17'd0;
      else begin
        // full space only without the device test, which would take too long
        region = 17'h10000;
        mask = {1'b0, 1'b1, 1'($urandom_range(1))};
      end
      if ($urandom_range(3) != 0) set_register(mbist_pkg::CFG_BASE, {1'b0, base});
      if ($urandom_range(3) != 0) set_register(mbist_pkg::CFG_REGION, region);
      if ($urandom_range(3) != 0) set_register(mbist_pkg::CFG_MASK, 17'(mask));
      repeat ($urandom_range(4, 1)) begin
        if ($urandom_range(99) < 10) begin
          send_item(KIND_ACK, 16'($urandom));
        end else begin
          bad = ($urandom_range(99) < 45) ? int'($urandom_range(40)) : -1;
          drive_run(400, bad, 8, n);
          done_items += n;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int waited;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = mbist_pkg::CFG_BASE;
    cfg_data  = '0;
    in_valid  = 1'b0;
    kind      = KIND_START;
    read_data = '0;
    // register and sequencer state after reset
    cfg_base   = 16'd0;
    cfg_region = 17'h10000;
    cfg_mask   = 3'b111;
    seq_phase  = mbist_pkg::PH_IDLE;
    walk_off   = '0;
    probe_off  = '0;
    walk_pat   = '0;
    want_word  = '0;
    read_owed  = 1'b0;
    owed_test  = mbist_pkg::FT_NONE;
    owed_value = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_idle_ack();
    test_empty_mask();
    test_zero_region();
    test_data_bus_fault();
    test_address_wrap();
    test_device_fault();
    test_restart_live_config();
    test_backpressure();
    test_full_address_space();
    test_random_runs();

    // let the last results out, bounded, then a few quiet cycles
    in_valid <= 1'b0;
    waited = 0;
    while (ops_due.size() != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (8) @(negedge clk);
    if (ops_due.size() != 0) begin
      mismatches += ops_due.size();
      $display("%0t: missing results, expected %0d more, actual 0",
               $time, ops_due.size());
    end

    $display("Covered %0d items, %0d results checked (%0d pass, %0d fail verdicts).",
             items_sent, results_checked, pass_verdicts, fail_verdicts);
    $display("Restarts mid-run: %0d, register writes: %0d, input stall cycles: %0d.",
             restarts, reg_writes, input_stalls);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout, %0d results still owed", $time, ops_due.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
rtl/core/mbist_pkg.sv
rtl/core/mbist_step.sv
rtl/core/memory_bus_and_cell_self_test.sv
tb/tb_memory_bus_and_cell_self_test.sv
